### design/ntfsrl_pkg.sv
// ntfsrl_pkg: shared types, codes and helpers for the run-list decoder.
// No dependencies; every other file in the design refers to it by scoped names.
package ntfsrl_pkg;

   // Result event codes
   localparam logic [2:0] EV_RUN       = 3'd0;
   localparam logic [2:0] EV_MATCH     = 3'd1;
   localparam logic [2:0] EV_DIFFER    = 3'd2;
   localparam logic [2:0] EV_OVERFLOW  = 3'd3;
   localparam logic [2:0] EV_MALFORMED = 3'd4;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_BPC  = 2'd0;
   localparam logic [1:0] CSR_EXP  = 2'd1;
   localparam logic [1:0] CSR_AREA = 2'd2;

   // Reset values of the registers
   localparam logic [21:0] BPC_RESET  = 22'd4096;
   localparam logic [47:0] EXP_RESET  = 48'd0;
   localparam logic [10:0] AREA_RESET = 11'd1024;

   // List position saturates here
   localparam logic [10:0] POS_MAX = 11'h7FF;

   // Largest legal nibble in a header byte
   localparam logic [3:0] NIBBLE_MAX = 4'd8;

   // Queue between parser and arithmetic
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_OFFSET
   } phase_type;

   // What the back end has to do with a queue entry
   typedef enum logic [1:0] {
      K_NONE,
      K_RUN,
      K_END,
      K_MALFORMED
   } kind_type;

   typedef struct packed {
      logic        start;
      kind_type    kind;
      logic [63:0] cluster;
      logic [63:0] length;
   } qentry_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic avail;
   } qstat_type;

   // Sign-extend an n-byte little-endian offset; zero bytes means offset zero
   function automatic logic [63:0] sign_extend_offset(input logic [63:0] acc,
                                                      input logic [3:0]  n);
      logic [63:0] r;
      begin
         case (n)
            4'd1:    r = {{56{acc[7]}},  acc[7:0]};
            4'd2:    r = {{48{acc[15]}}, acc[15:0]};
            4'd3:    r = {{40{acc[23]}}, acc[23:0]};
            4'd4:    r = {{32{acc[31]}}, acc[31:0]};
            4'd5:    r = {{24{acc[39]}}, acc[39:0]};
            4'd6:    r = {{16{acc[47]}}, acc[47:0]};
            4'd7:    r = {{8{acc[55]}},  acc[55:0]};
            4'd8:    r = acc;
            default: r = 64'd0;
         endcase
         return r;
      end
   endfunction

endpackage

### design/ntfsrl_front.sv
// ntfsrl_front: byte parser. Decodes header bytes, gathers length and offset
// bytes, keeps the running cluster number and queues run / end events.
// Depends on ntfsrl_pkg.
module ntfsrl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           list_byte,
   input  logic                 start_of_list,
   input  logic [10:0]          run_area_bytes,
   output ntfsrl_pkg::push_type push
);

   ntfsrl_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  len_need_ff, len_need_in;
   logic [3:0]  off_need_ff, off_need_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] len_acc_ff, len_acc_in;
   logic [63:0] off_acc_ff, off_acc_in;
   logic [63:0] clus_ff, clus_in;
   logic [10:0] pos_ff, pos_in;
   logic        fin_ff, fin_in;

   logic [3:0]  lo_nib, hi_nib;
   logic [3:0]  idx_next;
   logic [10:0] pos_cur;
   logic [63:0] run_len;
   logic        finish;

   assign lo_nib   = list_byte[3:0];
   assign hi_nib   = list_byte[7:4];
   assign idx_next = {1'b0, idx_ff} + 4'd1;

   // Next-state and event decode for one accepted beat
   always_comb begin
      phase_in    = phase_ff;
      len_need_in = len_need_ff;
      off_need_in = off_need_ff;
      idx_in      = idx_ff;
      len_acc_in  = len_acc_ff;
      off_acc_in  = off_acc_ff;
      clus_in     = clus_ff;
      pos_in      = pos_ff;
      fin_in      = fin_ff;
      pos_cur     = pos_ff;
      run_len     = len_acc_ff;
      finish      = 1'b0;

      push.valid         = 1'b0;
      push.entry.start   = start_of_list;
      push.entry.kind    = ntfsrl_pkg::K_NONE;
      push.entry.cluster = 64'd0;
      push.entry.length  = 64'd0;

      if (accept) begin
         // start of list wipes the running state first
         if (start_of_list) begin
            phase_in    = ntfsrl_pkg::PH_HEADER;
            len_need_in = 4'd0;
            off_need_in = 4'd0;
            idx_in      = 3'd0;
            len_acc_in  = 64'd0;
            off_acc_in  = 64'd0;
            clus_in     = 64'd0;
            pos_in      = 11'd0;
            fin_in      = 1'b0;
            push.valid  = 1'b1;
         end
         pos_cur = pos_in;

         if (!fin_in) begin
            if (pos_cur != ntfsrl_pkg::POS_MAX) begin
               pos_in = pos_cur + 11'd1;
            end
            unique case (phase_in)
               ntfsrl_pkg::PH_HEADER: begin
                  if (pos_cur >= run_area_bytes || lo_nib == 4'd0) begin
                     fin_in          = 1'b1;
                     push.valid      = 1'b1;
                     push.entry.kind = ntfsrl_pkg::K_END;
                  end else if (lo_nib > ntfsrl_pkg::NIBBLE_MAX ||
                               hi_nib > ntfsrl_pkg::NIBBLE_MAX) begin
                     fin_in          = 1'b1;
                     push.valid      = 1'b1;
                     push.entry.kind = ntfsrl_pkg::K_MALFORMED;
                  end else begin
                     len_need_in = lo_nib;
                     off_need_in = hi_nib;
                     idx_in      = 3'd0;
                     len_acc_in  = 64'd0;
                     off_acc_in  = 64'd0;
                     phase_in    = ntfsrl_pkg::PH_LENGTH;
                  end
               end
               ntfsrl_pkg::PH_LENGTH: begin
                  len_acc_in[{idx_ff, 3'b000} +: 8] = list_byte;
                  run_len = len_acc_in;
                  if (idx_next == len_need_ff) begin
                     idx_in = 3'd0;
                     if (off_need_ff == 4'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = ntfsrl_pkg::PH_OFFSET;
                     end
                  end else begin
                     idx_in = idx_next[2:0];
                  end
               end
               ntfsrl_pkg::PH_OFFSET: begin
                  off_acc_in[{idx_ff, 3'b000} +: 8] = list_byte;
                  if (idx_next == off_need_ff) begin
                     finish = 1'b1;
                  end else begin
                     idx_in = idx_next[2:0];
                  end
               end
               default: begin
                  phase_in = ntfsrl_pkg::PH_HEADER;
               end
            endcase

            // run complete: move the cluster number and queue the run
            if (finish) begin
               clus_in = clus_ff +
                  ntfsrl_pkg::sign_extend_offset(off_acc_in, off_need_ff);
               push.valid         = 1'b1;
               push.entry.kind    = ntfsrl_pkg::K_RUN;
               push.entry.cluster = clus_in;
               push.entry.length  = run_len;
               phase_in           = ntfsrl_pkg::PH_HEADER;
               idx_in             = 3'd0;
               len_acc_in         = 64'd0;
               off_acc_in         = 64'd0;
            end
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ntfsrl_pkg::PH_HEADER;
         len_need_ff <= 4'd0;
         off_need_ff <= 4'd0;
         idx_ff      <= 3'd0;
         len_acc_ff  <= 64'd0;
         off_acc_ff  <= 64'd0;
         clus_ff     <= 64'd0;
         pos_ff      <= 11'd0;
         fin_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         len_need_ff <= len_need_in;
         off_need_ff <= off_need_in;
         idx_ff      <= idx_in;
         len_acc_ff  <= len_acc_in;
         off_acc_ff  <= off_acc_in;
         clus_ff     <= clus_in;
         pos_ff      <= pos_in;
         fin_ff      <= fin_in;
      end
   end

endmodule

### design/ntfsrl_queue.sv
// ntfsrl_queue: short FIFO of decoded events between the parser and the
// arithmetic back end. Depends on ntfsrl_pkg.
module ntfsrl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ntfsrl_pkg::push_type   push,
   input  logic                   pop,
   output ntfsrl_pkg::qentry_type head,
   output ntfsrl_pkg::qstat_type  stat
);

   ntfsrl_pkg::qentry_type slot_ff [ntfsrl_pkg::QUEUE_DEPTH];
   logic [ntfsrl_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [ntfsrl_pkg::QCNT_W-1:0] count_ff, count_in;

   assign head       = slot_ff[rd_ff];
   assign stat.full  = (count_ff == ntfsrl_pkg::QCNT_W'(ntfsrl_pkg::QUEUE_DEPTH));
   assign stat.avail = (count_ff != '0);

   // Occupancy
   always_comb begin
      count_in = count_ff;
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + ntfsrl_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - ntfsrl_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push.valid) wr_ff <= wr_ff + ntfsrl_pkg::QPTR_W'(1);
         if (pop)        rd_ff <= rd_ff + ntfsrl_pkg::QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.entry;
      end
   end

endmodule

### design/ntfsrl_back.sv
// ntfsrl_back: scales cluster number and length by the cluster size in split
// multiplies, keeps the byte total, checks the size limit and holds the result.
// Depends on ntfsrl_pkg.
module ntfsrl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ntfsrl_pkg::qentry_type head,
   input  ntfsrl_pkg::qstat_type  qstat,
   output logic                   pop,
   input  logic [21:0]            bytes_per_cluster,
   input  logic [47:0]            expected_total_bytes,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_event_code,
   output logic [63:0]            rsp_run_byte_offset,
   output logic [63:0]            rsp_run_byte_count,
   output logic [63:0]            rsp_bytes_so_far
);

   // stage 1: partial products
   logic                    s1_v_ff;
   logic                    s1_start_ff;
   ntfsrl_pkg::kind_type    s1_kind_ff;
   logic [53:0]             s1_clo_ff, s1_llo_ff;
   logic [31:0]             s1_chi_ff, s1_lhi_ff;
   // stage 2: 64-bit products
   logic                    s2_v_ff;
   logic                    s2_start_ff;
   ntfsrl_pkg::kind_type    s2_kind_ff;
   logic [63:0]             s2_from_ff, s2_cnt_ff;
   // stage 3: result register
   logic                    s3_v_ff, s3_v_in;
   logic [2:0]              s3_code_ff, s3_code_in;
   logic [63:0]             s3_off_ff, s3_off_in;
   logic [63:0]             s3_cnt_ff, s3_cnt_in;
   logic [63:0]             s3_tot_ff, s3_tot_in;
   // list totals
   logic [63:0]             total_ff, total_in;
   logic                    dead_ff, dead_in;

   logic        s3_free, s2_free, s1_free;
   logic        s2_move, s1_move;
   logic [63:0] tot_base;
   logic [64:0] sum_wide;
   logic [53:0] clo_prod, llo_prod;
   logic [31:0] chi_prod, lhi_prod;

   // Elastic advance, back to front
   assign s3_free = !s3_v_ff || !rsp_stall;
   assign s2_move = s2_v_ff && s3_free;
   assign s2_free = !s2_v_ff || s3_free;
   assign s1_move = s1_v_ff && s2_free;
   assign s1_free = !s1_v_ff || s2_free;
   assign pop     = qstat.avail && s1_free;

   // Split 64x22 products
   assign clo_prod = 54'(head.cluster[31:0]) * 54'(bytes_per_cluster);
   assign chi_prod = head.cluster[63:32] * {10'd0, bytes_per_cluster};
   assign llo_prod = 54'(head.length[31:0]) * 54'(bytes_per_cluster);
   assign lhi_prod = head.length[63:32] * {10'd0, bytes_per_cluster};

   // Totals, limit check and result formation
   always_comb begin
      tot_base   = s2_start_ff ? 64'd0 : total_ff;
      dead_in    = s2_start_ff ? 1'b0  : dead_ff;
      total_in   = tot_base;
      sum_wide   = {1'b0, tot_base} + {1'b0, s2_cnt_ff};
      s3_v_in    = 1'b0;
      s3_code_in = ntfsrl_pkg::EV_RUN;
      s3_off_in  = 64'd0;
      s3_cnt_in  = 64'd0;
      s3_tot_in  = tot_base;
      if (!dead_in) begin
         case (s2_kind_ff)
            ntfsrl_pkg::K_RUN: begin
               s3_v_in   = 1'b1;
               s3_off_in = s2_from_ff;
               s3_cnt_in = s2_cnt_ff;
               if (sum_wide > {17'd0, expected_total_bytes}) begin
                  s3_code_in = ntfsrl_pkg::EV_OVERFLOW;
                  dead_in    = 1'b1;
               end else begin
                  total_in  = sum_wide[63:0];
                  s3_tot_in = sum_wide[63:0];
               end
            end
            ntfsrl_pkg::K_END: begin
               s3_v_in    = 1'b1;
               dead_in    = 1'b1;
               s3_code_in = (tot_base == {16'd0, expected_total_bytes}) ?
                            ntfsrl_pkg::EV_MATCH : ntfsrl_pkg::EV_DIFFER;
            end
            ntfsrl_pkg::K_MALFORMED: begin
               s3_v_in    = 1'b1;
               dead_in    = 1'b1;
               s3_code_in = ntfsrl_pkg::EV_MALFORMED;
            end
            default: begin
               s3_v_in = 1'b0;
            end
         endcase
      end
   end

   // Control: stage valids and list totals
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         total_ff <= 64'd0;
         dead_ff  <= 1'b0;
      end else begin
         if (s1_free) s1_v_ff <= pop;
         if (s2_free) s2_v_ff <= s1_move;
         if (s3_free) s3_v_ff <= s2_move && s3_v_in;
         if (s2_move) begin
            total_ff <= total_in;
            dead_ff  <= dead_in;
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_start_ff <= head.start;
         s1_kind_ff  <= head.kind;
         s1_clo_ff   <= clo_prod;
         s1_chi_ff   <= chi_prod;
         s1_llo_ff   <= llo_prod;
         s1_lhi_ff   <= lhi_prod;
      end
      if (s1_move) begin
         s2_start_ff <= s1_start_ff;
         s2_kind_ff  <= s1_kind_ff;
         s2_from_ff  <= {10'd0, s1_clo_ff} + {s1_chi_ff, 32'd0};
         s2_cnt_ff   <= {10'd0, s1_llo_ff} + {s1_lhi_ff, 32'd0};
      end
      if (s2_move && s3_free) begin
         s3_code_ff <= s3_code_in;
         s3_off_ff  <= s3_off_in;
         s3_cnt_ff  <= s3_cnt_in;
         s3_tot_ff  <= s3_tot_in;
      end
   end

   assign rsp_valid           = s3_v_ff;
   assign rsp_event_code      = s3_code_ff;
   assign rsp_run_byte_offset = s3_off_ff;
   assign rsp_run_byte_count  = s3_cnt_ff;
   assign rsp_bytes_so_far    = s3_tot_ff;

endmodule

### design/ntfs_runlist_decoder.sv
// ntfs_runlist_decoder: top level of the NTFS run-list decoder; holds the
// config registers and ties parser, queue and back end together.
// Depends on ntfsrl_pkg, ntfsrl_front, ntfsrl_queue, ntfsrl_back.
//
//   channel   direction  handshake           beat carries
//   req_      in         req_valid/stall     list_byte, start_of_list
//   rsp_      out        rsp_valid/stall     event_code, offset, count, bytes_so_far
//   csr_      in         csr_valid/ready     index, data (always ready)
//
// One list byte per cycle while req_stall is low. A run result is queued when its
// last byte is parsed, then passes the two multiply stages and the result stage.
// Synchronous active-high reset clears parser, queue and stage valids; the
// registers return to 4096 / 0 / 1024. req_stall rises only when the 4-entry
// event queue is full, which takes a stalled result plus a full pipe.
module ntfs_runlist_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_list_byte,
   input  logic        req_start_of_list,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   output logic [63:0] rsp_run_byte_offset,
   output logic [63:0] rsp_run_byte_count,
   output logic [63:0] rsp_bytes_so_far,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [21:0] bpc_ff;
   logic [47:0] exp_ff;
   logic [10:0] area_ff;

   ntfsrl_pkg::push_type   push;
   ntfsrl_pkg::qentry_type head;
   ntfsrl_pkg::qstat_type  qstat;
   logic                   pop;
   logic                   req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = qstat.full;
   assign req_accept = req_valid && !req_stall;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff  <= ntfsrl_pkg::BPC_RESET;
         exp_ff  <= ntfsrl_pkg::EXP_RESET;
         area_ff <= ntfsrl_pkg::AREA_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ntfsrl_pkg::CSR_BPC:  bpc_ff  <= csr_data[21:0];
            ntfsrl_pkg::CSR_EXP:  exp_ff  <= csr_data;
            ntfsrl_pkg::CSR_AREA: area_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   ntfsrl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .list_byte      (req_list_byte),
      .start_of_list  (req_start_of_list),
      .run_area_bytes (area_ff),
      .push           (push)
   );

   ntfsrl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (qstat)
   );

   ntfsrl_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .qstat                (qstat),
      .pop                  (pop),
      .bytes_per_cluster    (bpc_ff),
      .expected_total_bytes (exp_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_run_byte_offset  (rsp_run_byte_offset),
      .rsp_run_byte_count   (rsp_run_byte_count),
      .rsp_bytes_so_far     (rsp_bytes_so_far)
   );

`ifndef SYNTHESIS
   // parser never writes into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !qstat.full)
      else $error("event pushed into full queue");

   // end and malformed results carry no run
   a_end_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == ntfsrl_pkg::EV_MATCH ||
                    rsp_event_code == ntfsrl_pkg::EV_DIFFER ||
                    rsp_event_code == ntfsrl_pkg::EV_MALFORMED)
      |-> rsp_run_byte_offset == 64'd0 && rsp_run_byte_count == 64'd0)
      else $error("end result with nonzero run fields");

   // an accepted run is inside the total and the total inside the limit
   a_run_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == ntfsrl_pkg::EV_RUN
      |-> rsp_bytes_so_far >= rsp_run_byte_count &&
          rsp_bytes_so_far <= {16'd0, exp_ff})
      else $error("run total out of bounds");
`endif

endmodule
